>>> hw/rtl/generalized_advantage_estimator_unit_macros.svh
// assertion macros shared by the gae rtl
`ifndef GENERALIZED_ADVANTAGE_ESTIMATOR_UNIT_MACROS_SVH
`define GENERALIZED_ADVANTAGE_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gae_pkg.sv
package gae_pkg;

  localparam int FIELD_W     = 32;
  localparam int COEF_W      = 17;
  localparam int COEF_FRAC   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COEF_W-1:0] COEF_ONE          = 17'd65536;
  localparam logic [COEF_W-1:0] DISCOUNT_RESET    = 17'd64881;
  localparam logic [COEF_W-1:0] TRACE_DECAY_RESET = 17'd62259;
  localparam logic [COEF_W-1:0] GL_RESET =
    17'(((64'd64881 * 64'd62259) + 64'd32768) >> 16);

  localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_DECAY = 2'd1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] reward;
    logic signed [FIELD_W-1:0] state_value;
    logic                      episode_done;
    logic                      first_of_rollout;
    logic signed [FIELD_W-1:0] bootstrap_value;
  } step_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] advantage;
    logic signed [FIELD_W-1:0] return_value;
  } result_t;

  // queue entry: reward minus value already formed by the front
  typedef struct packed {
    logic signed [FIELD_W:0]   diff;
    logic signed [FIELD_W-1:0] state_value;
    logic signed [FIELD_W-1:0] bootstrap_value;
    logic                      done;
    logic                      first;
  } work_t;

endpackage

>>> hw/rtl/generalized_advantage_estimator_unit.sv
// path: front entry register, queue, then the back-end steps (pop, multiply, sum and
//   saturate, output); the back end starts a request only after the last one left the
//   output step, since that loop carries the running advantage to the next request
// front end and 2-entry queue take requests at one per cycle until the queue fills
// reset (rst, synchronous, active high): queue and pipeline empty, running advantage
//   and later value zero, discount 64881 and trace decay 62259
module generalized_advantage_estimator_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // rollout steps, newest first
  input  logic                                step_valid,
  output logic                                step_stall,
  input  gae_pkg::step_t                      step,
  // advantage and return per step
  output logic                                result_valid,
  input  logic                                result_stall,
  output gae_pkg::result_t                    result,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gae_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gae_pkg::COEF_W-1:0]          cfg_data
);

  // results saturate to the data width, which the 32-bit fields cap
  localparam int SAT_W = (DATA_WIDTH > gae_pkg::FIELD_W) ? gae_pkg::FIELD_W : DATA_WIDTH;

  logic [gae_pkg::COEF_W-1:0]   discount;
  logic [gae_pkg::COEF_W-1:0]   trace_decay;
  logic [gae_pkg::COEF_W-1:0]   gl_coef;
  logic [gae_pkg::COEF_W-1:0]   cfg_clamped;
  logic [2*gae_pkg::COEF_W-1:0] gl_prod;
  logic                         cfg_write;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  gae_pkg::work_t q_wr;
  gae_pkg::work_t q_rd;

  // register writes are always taken; coefficients above one act as one
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid & cfg_ready;
  assign cfg_clamped = (cfg_data > gae_pkg::COEF_ONE) ? gae_pkg::COEF_ONE : cfg_data;

  // gamma*lambda rounded to Q1.16, refreshed every cycle from the registers;
  // a request passes the front entry register, the queue and the pop step before
  // it reaches the multiplier, so a write taken with it is already folded in
  assign gl_prod = discount * trace_decay
                 + (2*gae_pkg::COEF_W)'(1 << (gae_pkg::COEF_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      discount    <= gae_pkg::DISCOUNT_RESET;
      trace_decay <= gae_pkg::TRACE_DECAY_RESET;
      gl_coef     <= gae_pkg::GL_RESET;
    end else begin
      gl_coef <= gl_prod[gae_pkg::COEF_FRAC +: gae_pkg::COEF_W];
      if (cfg_write) begin
        case (cfg_index)
          gae_pkg::CFG_DISCOUNT: begin
            discount <= cfg_clamped;
          end
          gae_pkg::CFG_TRACE_DECAY: begin
            trace_decay <= cfg_clamped;
          end
          default: begin
            // unknown index: write dropped
          end
        endcase
      end
    end
  end

  // front: takes requests and forms reward minus value
  gae_front u_front (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_stall (step_stall),
    .step       (step),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr)
  );

  // short queue decoupling front and back
  gae_fifo #(
    .DEPTH (gae_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: td error, advantage recurrence, saturation and output register
  gae_back #(
    .SAT_W (SAT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .discount     (discount),
    .gl_coef      (gl_coef),
    .q_empty      (q_empty),
    .q_data       (q_rd),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> hw/rtl/gae_front.sv
module gae_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_valid,
  output logic            step_stall,
  input  gae_pkg::step_t  step,
  input  logic            q_full,
  output logic            q_push,
  output gae_pkg::work_t  q_data
);

  logic           ent_vld;
  logic           ent_vld_next;
  gae_pkg::work_t ent;
  logic           take;

  assign step_stall   = ent_vld & q_full;
  assign take         = step_valid & ~step_stall;
  assign q_push       = ent_vld & ~q_full;
  assign q_data       = ent;
  assign ent_vld_next = take | (ent_vld & q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= 1'b0;
    end else begin
      ent_vld <= ent_vld_next;
    end
    if (take) begin
      ent.diff            <= 33'(step.reward) - 33'(step.state_value);
      ent.state_value     <= step.state_value;
      ent.bootstrap_value <= step.bootstrap_value;
      ent.done            <= step.episode_done;
      ent.first           <= step.first_of_rollout;
    end
  end

endmodule

>>> hw/rtl/gae_fifo.sv
`include "generalized_advantage_estimator_unit_macros.svh"

module gae_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gae_pkg::work_t wr_data,
  input  logic           pop,
  output gae_pkg::work_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  gae_pkg::work_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `GAE_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, cnt == $past(cnt) + 1'b1, "fifo count slip")

endmodule

>>> hw/rtl/gae_back.sv
`include "generalized_advantage_estimator_unit_macros.svh"

module gae_back #(
  parameter int SAT_W = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gae_pkg::COEF_W-1:0]    discount,
  input  logic [gae_pkg::COEF_W-1:0]    gl_coef,
  input  logic                          q_empty,
  input  gae_pkg::work_t                q_data,
  output logic                          q_pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output gae_pkg::result_t              result
);

  localparam int SUM_W  = 36;
  localparam int PROD_W = 50;
  localparam int DW     = gae_pkg::FIELD_W;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 36'sd1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    PROD_W'(64'sd1 <<< (gae_pkg::COEF_FRAC - 1));

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} state_t;

  state_t                    state;
  gae_pkg::work_t            cur;
  logic signed [PROD_W-1:0]  p_next;
  logic signed [PROD_W-1:0]  p_prev;
  logic signed [DW-1:0]      running_adv;
  logic signed [DW-1:0]      later_val;
  logic signed [DW-1:0]      nxt_sel;
  logic signed [DW-1:0]      prv_sel;
  logic signed [SUM_W-1:0]   adv_sum;
  logic signed [SUM_W-1:0]   ret_sum;
  logic                      out_free;

  function automatic logic signed [DW-1:0] sat(input logic signed [SUM_W-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[DW-1:0];
    end
    if (x < SAT_LO) begin
      return SAT_LO[DW-1:0];
    end
    return x[DW-1:0];
  endfunction

  assign q_pop    = (state == S_IDLE) & ~q_empty;
  assign out_free = ~result_valid | ~result_stall;
  assign nxt_sel  = cur.first ? cur.bootstrap_value : later_val;
  assign prv_sel  = cur.first ? '0 : running_adv;

  // products rounded to nearest (halves up) are the upper bits of the biased products
  always_comb begin
    adv_sum = SUM_W'(cur.diff);
    if (!cur.done) begin
      adv_sum = adv_sum
              + SUM_W'($signed(p_next[PROD_W-1:gae_pkg::COEF_FRAC]))
              + SUM_W'($signed(p_prev[PROD_W-1:gae_pkg::COEF_FRAC]));
    end
  end

  assign ret_sum = SUM_W'(running_adv) + SUM_W'(cur.state_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      running_adv  <= '0;
      later_val    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          running_adv <= sat(adv_sum);
          later_val   <= cur.state_value;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a new result replaces one taken in the same cycle
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == S_MUL) begin
      p_next <= $signed({1'b0, discount}) * nxt_sel + ROUND_HALF;
      p_prev <= $signed({1'b0, gl_coef}) * prv_sel + ROUND_HALF;
    end
    if (state == S_OUT && out_free) begin
      result.advantage    <= running_adv;
      result.return_value <= sat(ret_sum);
    end
  end

  `GAE_ASSERT_NEXT(a_pop_starts, q_pop, state == S_MUL, "popped request not started")
  `GAE_ASSERT_NEXT(a_later_val, state == S_SUM, later_val == $past(cur.state_value), "later value lost")
  `GAE_ASSERT_NOW(a_out_from_out, $rose(result_valid), $past(state == S_OUT), "result outside output step")

endmodule
